FILE: rtl/core/cdt_pkg.sv
// Package for the countdown timer core: command and mode codes, field widths,
// divider status type. No dependencies.
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int TimeW  = 32;
  localparam int LevelW = 8;
  localparam int CmdW   = 3;
  localparam int ModeW  = 2;
  localparam int DivW   = TimeW + LevelW;
  localparam int QCntW  = $clog2(LevelW);

  localparam logic [TimeW-1:0]  DefaultDuration = 32'd1200000;
  localparam logic [LevelW-1:0] LevelMax        = 8'd255;

  localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_START  = 3'd1;
  localparam logic [CmdW-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CmdW-1:0] CMD_RESUME = 3'd3;
  localparam logic [CmdW-1:0] CMD_ADD    = 3'd4;
  localparam logic [CmdW-1:0] CMD_STOP   = 3'd5;

  localparam logic [ModeW-1:0] MODE_IDLE    = 2'd0;
  localparam logic [ModeW-1:0] MODE_RUNNING = 2'd1;
  localparam logic [ModeW-1:0] MODE_PAUSED  = 2'd2;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [LevelW-1:0] quot;
    logic              rem_nz;
  } div_sts_t;

endpackage

FILE: rtl/core/cdt_if.sv
// Valid/ready channel interfaces for the countdown timer core.
// Depends on cdt_pkg.
`timescale 1ns / 1ps

interface cdt_in_if import cdt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [TimeW-1:0] extra_time;

  modport source (output valid, cmd, extra_time, input ready);
  modport sink   (input valid, cmd, extra_time, output ready);
endinterface

interface cdt_out_if import cdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  run_state;
  logic [TimeW-1:0]  time_left;
  logic [LevelW-1:0] red_level;
  logic [LevelW-1:0] green_level;
  logic              color_changed;
  logic              expired;

  modport source (output valid, run_state, time_left, red_level, green_level,
                  color_changed, expired, input ready);
  modport sink   (input valid, run_state, time_left, red_level, green_level,
                  color_changed, expired, output ready);
endinterface

FILE: rtl/core/cdt_div.sv
// Restoring divider, one quotient bit per cycle, for the colour gradient.
// Depends on cdt_pkg.
`timescale 1ns / 1ps

module cdt_div import cdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivW-1:0]  dividend,
  input  logic [TimeW-1:0] divisor,
  output div_sts_t         sts
);

  logic [DivW-1:0]   rem_r, rem_nxt;
  logic [DivW-1:0]   den_r, den_nxt;
  logic [LevelW-1:0] q_r, q_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              fits;

  assign fits = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      den_nxt  = {1'b0, divisor, {(LevelW-1){1'b0}}};
      cnt_nxt  = QCntW'(LevelW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - den_r;
      end
      q_nxt   = {q_r[LevelW-2:0], fits};
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy   = busy_r;
  assign sts.done   = done_r;
  assign sts.quot   = q_r;
  assign sts.rem_nz = (rem_r != '0);

endmodule

FILE: rtl/core/countdown_timer_with_color_gradient_core.sv
// Countdown timer core with red/green gradient. Most beats go from accept to ST_DONE
// and on to the output register; a running tick passes ST_PREP, ST_DIV and ST_WAIT
// first, the divider giving one quotient bit per cycle (a zero duration skips it).
// One beat in flight; next beat taken once the result sits in the output register.
// Reset (synchronous, rst_n low): idle, no time left, colour 0/0, duration 1200000.
// Depends on cdt_pkg, cdt_if, cdt_div.
`timescale 1ns / 1ps

module countdown_timer_with_color_gradient_core import cdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TimeW-1:0] cfg_wdata,
  cdt_in_if.sink           in_bus,
  cdt_out_if.source        out_bus
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        st_r, st_nxt;
  logic [TimeW-1:0]  dur_r;
  logic [ModeW-1:0]  mode_r, mode_nxt;
  logic [TimeW-1:0]  rem_r, rem_nxt;
  logic [LevelW-1:0] red_r, red_nxt;
  logic [LevelW-1:0] grn_r, grn_nxt;
  logic              chg_r, chg_nxt;
  logic              exp_r, exp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ModeW-1:0]  o_mode_r;
  logic [TimeW-1:0]  o_time_r;
  logic [LevelW-1:0] o_red_r, o_grn_r;
  logic              o_chg_r, o_exp_r;

  logic              accept;
  logic              out_free;
  logic              div_start;
  logic [TimeW-1:0]  part;
  logic [DivW-1:0]   dividend;
  logic [TimeW-1:0]  extra_c;
  logic [TimeW:0]    sum;
  logic [LevelW-1:0] new_red, new_grn;
  div_sts_t          div_sts;

  assign in_bus.ready = (st_r == ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  assign part     = (rem_r > dur_r) ? dur_r : rem_r;
  assign dividend = {part, {LevelW{1'b0}}} - {{LevelW{1'b0}}, part};
  assign extra_c  = (in_bus.extra_time > dur_r) ? dur_r : in_bus.extra_time;
  assign sum      = {1'b0, rem_r} + {1'b0, extra_c};
  // red = 255 - q, less one when the division leaves a remainder
  assign new_grn  = div_sts.quot;
  assign new_red  = LevelMax - div_sts.quot - {{(LevelW-1){1'b0}}, div_sts.rem_nz};

  cdt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dur_r),
    .sts      (div_sts)
  );

  always_comb begin
    st_nxt        = st_r;
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    red_nxt       = red_r;
    grn_nxt       = grn_r;
    chg_nxt       = chg_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          chg_nxt = 1'b0;
          exp_nxt = 1'b0;
          st_nxt  = ST_DONE;
          case (in_bus.cmd)
            CMD_TICK: begin
              if (mode_r == MODE_RUNNING) begin
                if (rem_r != '0) begin
                  rem_nxt = rem_r - 1'b1;
                end
                st_nxt = ST_PREP;
              end
            end
            CMD_START: begin
              mode_nxt = MODE_RUNNING;
              rem_nxt  = dur_r;
            end
            CMD_PAUSE: begin
              if (mode_r == MODE_RUNNING) begin
                mode_nxt = MODE_PAUSED;
              end
            end
            CMD_RESUME: begin
              if (mode_r == MODE_PAUSED) begin
                mode_nxt = MODE_RUNNING;
              end
            end
            CMD_ADD: begin
              if (mode_r != MODE_IDLE) begin
                rem_nxt = (sum > {1'b0, dur_r}) ? dur_r : sum[TimeW-1:0];
              end
            end
            CMD_STOP: begin
              mode_nxt = MODE_IDLE;
              rem_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PREP: begin
        exp_nxt = (rem_r == '0);
        if (dur_r == '0) begin
          red_nxt = LevelMax;
          grn_nxt = '0;
          chg_nxt = (red_r != LevelMax) || (grn_r != '0);
          st_nxt  = ST_DONE;
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          red_nxt = new_red;
          grn_nxt = new_grn;
          chg_nxt = (red_r != new_red) || (grn_r != new_grn);
          st_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      dur_r       <= DefaultDuration;
      mode_r      <= MODE_IDLE;
      rem_r       <= '0;
      red_r       <= '0;
      grn_r       <= '0;
      chg_r       <= 1'b0;
      exp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      rem_r       <= rem_nxt;
      red_r       <= red_nxt;
      grn_r       <= grn_nxt;
      chg_r       <= chg_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        dur_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && out_free) begin
      o_mode_r <= mode_r;
      o_time_r <= (mode_r == MODE_IDLE) ? '0 : rem_r;
      o_red_r  <= red_r;
      o_grn_r  <= grn_r;
      o_chg_r  <= chg_r;
      o_exp_r  <= exp_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.run_state     = o_mode_r;
  assign out_bus.time_left     = o_time_r;
  assign out_bus.red_level     = o_red_r;
  assign out_bus.green_level   = o_grn_r;
  assign out_bus.color_changed = o_chg_r;
  assign out_bus.expired       = o_exp_r;

`ifndef SYNTH
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !div_sts.busy)
    else $error("beat taken while divider busy");

  a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.expired) |->
      (out_bus.time_left == '0 && out_bus.run_state == MODE_RUNNING))
    else $error("expiry flagged with time left");

  a_changed_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.color_changed) |-> out_bus.run_state == MODE_RUNNING)
    else $error("colour change outside running");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> st_r == ST_WAIT)
    else $error("divider result not awaited");
`endif

endmodule

FILE: bench/tb_countdown_timer_with_color_gradient_core.sv
// Testbench for countdown_timer_with_color_gradient_core: directed and random command beats,
// checked against an in-bench model of the timer state and colour gradient.
// Depends on cdt_pkg, cdt_if and the core RTL.
`timescale 1ns / 1ps

module tb_countdown_timer_with_color_gradient_core;
  import cdt_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_7 = 3'd7;
  localparam int CycleLimit      = 200000;
  localparam int SettleCycles    = 24;
  localparam int ItemsPerSetting = 110;
  localparam int HoldOffCycles   = 300;
  localparam int NumSettings     = 9;

  typedef struct packed {
    logic [ModeW-1:0]  run_state;
    logic [TimeW-1:0]  time_left;
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic              color_changed;
    logic              expired;
  } readout_t;

  class countdown_twin;
    logic [TimeW-1:0]  duration;
    logic [ModeW-1:0]  mode;
    logic [TimeW-1:0]  remaining;
    logic [LevelW-1:0] shown_red;
    logic [LevelW-1:0] shown_green;
    readout_t          due_readouts[$];
    int                errors;

    function new();
      duration    = DefaultDuration;
      mode        = MODE_IDLE;
      remaining   = '0;
      shown_red   = '0;
      shown_green = '0;
      errors      = 0;
    endfunction

    function void shade(input logic [TimeW-1:0] left, output logic [LevelW-1:0] red,
                        output logic [LevelW-1:0] green);
      logic [63:0] span;
      logic [63:0] part;
      logic [63:0] g;
      logic [63:0] r;
      span = 64'(duration);
      part = 64'(left);
      if (span == 0) begin
        red   = LevelMax;
        green = '0;
      end else begin
        if (part > span) part = span;
        g     = (64'(LevelMax) * part) / span;
        r     = (64'(LevelMax) * (span - part)) / span;
        green = g[LevelW-1:0];
        red   = r[LevelW-1:0];
      end
    endfunction

    // Advance the timer by one accepted input beat and queue the readout it owes.
    function void note_command(logic [CmdW-1:0] cmd, logic [TimeW-1:0] extra);
      readout_t          r;
      logic [TimeW:0]    sum;
      logic [TimeW-1:0]  capped;
      logic [LevelW-1:0] red;
      logic [LevelW-1:0] green;
      r.color_changed = 1'b0;
      r.expired       = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (mode == MODE_RUNNING) begin
            if (remaining != 0) remaining = remaining - 1'b1;
            shade(remaining, red, green);
            if (red != shown_red || green != shown_green) begin
              shown_red       = red;
              shown_green     = green;
              r.color_changed = 1'b1;
            end
            if (remaining == 0) r.expired = 1'b1;
          end
        end
        CMD_START: begin
          mode      = MODE_RUNNING;
          remaining = duration;
        end
        CMD_PAUSE:  if (mode == MODE_RUNNING) mode = MODE_PAUSED;
        CMD_RESUME: if (mode == MODE_PAUSED) mode = MODE_RUNNING;
        CMD_ADD: begin
          if (mode != MODE_IDLE) begin
            capped = (extra > duration) ? duration : extra;
            sum    = {1'b0, remaining} + {1'b0, capped};
            if (sum > {1'b0, duration}) sum = {1'b0, duration};
            remaining = sum[TimeW-1:0];
          end
        end
        CMD_STOP: begin
          mode      = MODE_IDLE;
          remaining = '0;
        end
        default: ;
      endcase
      r.run_state   = mode;
      r.time_left   = (mode == MODE_IDLE) ? '0 : remaining;
      r.red_level   = shown_red;
      r.green_level = shown_green;
      due_readouts.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (due_readouts.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, got %p", $time, got);
      end else begin
        want = due_readouts.pop_front();
        compare_field("run_state", want.run_state, got.run_state);
        compare_field("time_left", want.time_left, got.time_left);
        compare_field("red_level", want.red_level, got.red_level);
        compare_field("green_level", want.green_level, got.green_level);
        compare_field("color_changed", want.color_changed, got.color_changed);
        compare_field("expired", want.expired, got.expired);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TimeW-1:0] cfg_wdata;

  cdt_in_if  in_ch ();
  cdt_out_if out_ch ();

  countdown_timer_with_color_gradient_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_ch),
    .out_bus   (out_ch)
  );

  countdown_twin    tracker;
  int               sender_idle_pct;
  int               receiver_idle_pct;
  int               stall_request;
  logic [TimeW-1:0] durations [NumSettings] = '{
    32'd3, 32'd1, 32'd40, 32'd255, 32'd1200000, 32'd97, 32'hFFFF_FFFF, 32'd256, 32'd2
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    readout_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.run_state, out_ch.time_left, out_ch.red_level, out_ch.green_level,
               out_ch.color_changed, out_ch.expired};
        tracker.check_readout(got);
      end
      if (in_ch.valid && in_ch.ready) tracker.note_command(in_ch.cmd, in_ch.extra_time);
    end
  end

  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] extra);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.extra_time <= extra;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_for_readouts();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_duration(input logic [TimeW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.duration = value;
  endtask

  function automatic logic [CmdW-1:0] pick_command();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return CMD_TICK;
    else if (roll < 62) return CMD_START;
    else if (roll < 69) return CMD_PAUSE;
    else if (roll < 76) return CMD_RESUME;
    else if (roll < 88) return CMD_ADD;
    else if (roll < 95) return CMD_STOP;
    else if (roll < 97) return CMD_SPARE_6;
    else return CMD_SPARE_7;
  endfunction

  function automatic logic [TimeW-1:0] pick_extra(logic [TimeW-1:0] span);
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  initial begin
    tracker           = new();
    sender_idle_pct   = 35;
    receiver_idle_pct = 55;
    stall_request     = 0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.extra_time  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wrong-state and unknown commands from idle, then a run at the default duration
    send_command(CMD_TICK, '0);
    send_command(CMD_PAUSE, '0);
    send_command(CMD_RESUME, '0);
    send_command(CMD_ADD, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_6, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_7, '0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_ADD, 32'hFFFF_FFFF);
    send_command(CMD_PAUSE, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_PAUSE, '0);
    send_command(CMD_ADD, 32'd5);
    send_command(CMD_RESUME, '0);
    send_command(CMD_RESUME, '0);
    send_command(CMD_STOP, '0);

    // short run to expiry, repeated expiry, add after expiry
    wait_for_readouts();
    write_duration(32'd2);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_ADD, 32'd1);
    send_command(CMD_TICK, '0);
    send_command(CMD_STOP, '0);

    // zero duration: full red at once
    wait_for_readouts();
    write_duration('0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_STOP, '0);

    for (int s = 0; s < NumSettings; s++) begin
      if (s == 3) begin
        sender_idle_pct   = 55;
        receiver_idle_pct = 35;
      end
      if (s == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      wait_for_readouts();
      write_duration(durations[s]);
      for (int n = 0; n < ItemsPerSetting; n++) begin
        if (s == 0 && n == 40) stall_request = HoldOffCycles;
        send_command(pick_command(), pick_extra(tracker.duration));
      end
    end

    wait_for_readouts();
    repeat (SettleCycles) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_readouts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
